### src/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg: shared types, constants and tables for the half precision cosine
// Back-end fixed point uses 62 fraction bits; tables hold 56.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int HPC_TABLE_ENTRIES = 32;
  localparam int HPC_IDX_W         = $clog2(HPC_TABLE_ENTRIES);
  localparam int HPC_FRONT_STAGES  = 6;
  localparam int HPC_FRONT_CW      = $clog2(HPC_FRONT_STAGES + 1);
  localparam int HPC_QUEUE_DEPTH   = 8;

  localparam logic [63:0] HPC_INV_PI16 = 64'h00145f306dc9c883;
  localparam logic [63:0] HPC_PI16     = 64'h001921fb54442d18;
  localparam logic signed [63:0] HPC_ONE = 64'sh4000000000000000;
  localparam logic signed [63:0] HPC_C24 = 64'sh1555556 <<< 33;
  localparam logic signed [63:0] HPC_C6  = 64'sh1555556 <<< 35;

  localparam logic [15:0] HPC_QNAN    = 16'h7E00;
  localparam logic [4:0]  HPC_EXP_MAX = 5'h1f;

  typedef logic [1:0] hpc_mode_t;
  localparam hpc_mode_t RM_NEAREST = 2'd0;
  localparam hpc_mode_t RM_ZERO    = 2'd1;
  localparam hpc_mode_t RM_UP      = 2'd2;
  localparam hpc_mode_t RM_DOWN    = 2'd3;

  // word handed from the front end to the back end
  typedef struct packed {
    logic                  nan;
    logic [HPC_IDX_W-1:0]  idx;
    logic signed [63:0]    r;
  } hpc_item_t;

  // increment decision for a magnitude with discarded bits
  function automatic logic hpc_round_up(input hpc_mode_t mode, input logic neg,
                                        input logic lsb, input logic nz,
                                        input logic gt, input logic eq);
    logic up;
    up = 1'b0;
    if (nz) begin
      unique case (mode)
        RM_NEAREST: up = gt || (eq && lsb);
        RM_ZERO:    up = 1'b0;
        RM_UP:      up = !neg;
        RM_DOWN:    up = neg;
        default:    up = 1'b0;
      endcase
    end
    return up;
  endfunction

  function automatic logic signed [63:0] hpc_cos_rom(input logic [HPC_IDX_W-1:0] i);
    logic signed [63:0] v;
    unique case (i)
      5'd0:  v = 64'sh100000000000000;
      5'd1:  v = 64'shfb14be7fbae580;
      5'd2:  v = 64'shec835e79946a30;
      5'd3:  v = 64'shd4db3148750d18;
      5'd4:  v = 64'shb504f333f9de68;
      5'd5:  v = 64'sh8e39d9cd734648;
      5'd6:  v = 64'sh61f78a9abaa590;
      5'd7:  v = 64'sh31f17078d34c1a;
      5'd8:  v = 64'sd4;
      5'd9:  v = -64'sh31f17078d34c10;
      5'd10: v = -64'sh61f78a9abaa588;
      5'd11: v = -64'sh8e39d9cd734630;
      5'd12: v = -64'shb504f333f9de60;
      5'd13: v = -64'shd4db3148750d20;
      5'd14: v = -64'shec835e79946a30;
      5'd15: v = -64'shfb14be7fbae580;
      5'd16: v = -64'sh100000000000000;
      5'd17: v = -64'shfb14be7fbae580;
      5'd18: v = -64'shec835e79946a38;
      5'd19: v = -64'shd4db3148750d28;
      5'd20: v = -64'shb504f333f9de70;
      5'd21: v = -64'sh8e39d9cd734640;
      5'd22: v = -64'sh61f78a9abaa5b4;
      5'd23: v = -64'sh31f17078d34c32;
      5'd24: v = -64'sd13;
      5'd25: v = 64'sh31f17078d34c18;
      5'd26: v = 64'sh61f78a9abaa59c;
      5'd27: v = 64'sh8e39d9cd734628;
      5'd28: v = 64'shb504f333f9de58;
      5'd29: v = 64'shd4db3148750d18;
      5'd30: v = 64'shec835e79946a20;
      5'd31: v = 64'shfb14be7fbae578;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] hpc_sin_rom(input logic [HPC_IDX_W-1:0] i);
    logic signed [63:0] v;
    unique case (i)
      5'd0:  v = 64'sd0;
      5'd1:  v = 64'sh31f17078d34c14;
      5'd2:  v = 64'sh61f78a9abaa58c;
      5'd3:  v = 64'sh8e39d9cd734640;
      5'd4:  v = 64'shb504f333f9de60;
      5'd5:  v = 64'shd4db3148750d18;
      5'd6:  v = 64'shec835e79946a30;
      5'd7:  v = 64'shfb14be7fbae580;
      5'd8:  v = 64'sh100000000000000;
      5'd9:  v = 64'shfb14be7fbae580;
      5'd10: v = 64'shec835e79946a30;
      5'd11: v = 64'shd4db3148750d28;
      5'd12: v = 64'shb504f333f9de68;
      5'd13: v = 64'sh8e39d9cd734640;
      5'd14: v = 64'sh61f78a9abaa594;
      5'd15: v = 64'sh31f17078d34c2e;
      5'd16: v = 64'sd9;
      5'd17: v = -64'sh31f17078d34c1c;
      5'd18: v = -64'sh61f78a9abaa584;
      5'd19: v = -64'sh8e39d9cd734630;
      5'd20: v = -64'shb504f333f9de60;
      5'd21: v = -64'shd4db3148750d18;
      5'd22: v = -64'shec835e79946a20;
      5'd23: v = -64'shfb14be7fbae578;
      5'd24: v = -64'sh100000000000000;
      5'd25: v = -64'shfb14be7fbae580;
      5'd26: v = -64'shec835e79946a28;
      5'd27: v = -64'shd4db3148750d28;
      5'd28: v = -64'shb504f333f9de70;
      5'd29: v = -64'sh8e39d9cd734640;
      5'd30: v = -64'sh61f78a9abaa5b8;
      5'd31: v = -64'sh31f17078d34c36;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/half_precision_cosine_unit.sv
// A word passes through 6 front stages, the queue, 14 back stages and 5 rounding
//   stages before its done cycle.
// Throughput: one word per cycle while busy is low; the multiply pipelines of the back end set it.
// The receiver cannot stall; busy rises only if the queue could overflow.
// Reset (rst, synchronous, high) empties both pipelines and the queue and
//   sets rounding_mode to nearest even.
// ----------------------------------------------------------------------------
// half_precision_cosine_unit: binary16 cosine by table and polynomial
// Front end reduces x around k*pi/16, back end evaluates the short series
// against 32-entry cosine and sine tables and rounds to binary16.
// ----------------------------------------------------------------------------
module half_precision_cosine_unit
  import hpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = HPC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] x_bits,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  output logic        done,
  output logic [15:0] cos_bits,
  output logic        invalid_flag
);

  localparam int QLW = $clog2(QUEUE_DEPTH + 1);
  localparam int OCW = $clog2(QUEUE_DEPTH + HPC_FRONT_STAGES + 1);

  hpc_mode_t               rounding_mode;
  logic                    accept;
  logic                    f_valid;
  hpc_item_t               f_item;
  logic [HPC_FRONT_CW-1:0] f_level;
  logic                    q_pop;
  hpc_item_t               q_item;
  logic [QLW-1:0]          q_level;
  logic [OCW-1:0]          occupancy;

  // single configuration register; the user must write it only while idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_mode <= RM_NEAREST;
    end else if (cfg_write) begin
      rounding_mode <= cfg_data;
    end
  end

  // words in flight in the front end plus those queued must fit the queue,
  // since the back end drains without back-pressure
  assign occupancy = OCW'(q_level) + OCW'(f_level);
  assign busy      = (occupancy >= OCW'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  hpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .x_bits    (x_bits),
    .mode      (rounding_mode),
    .out_valid (f_valid),
    .out_item  (f_item),
    .level     (f_level)
  );

  hpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_item),
    .level (q_level)
  );

  hpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_pop),
    .in_item      (q_item),
    .mode         (rounding_mode),
    .done         (done),
    .cos_bits     (cos_bits),
    .invalid_flag (invalid_flag)
  );

`ifndef SYNTHESIS
  a_nan_code: assert property (@(posedge clk) disable iff (rst)
    done && invalid_flag |-> cos_bits == HPC_QNAN)
    else $error("invalid word without quiet NaN code");

  a_finite: assert property (@(posedge clk) disable iff (rst)
    done && !invalid_flag |-> cos_bits[14:10] != HPC_EXP_MAX)
    else $error("finite argument gave infinity or NaN");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done strobe straight after reset");
`endif

endmodule

### src/hpc_mul.sv
// ----------------------------------------------------------------------------
// hpc_mul: signed fixed-point multiply, 62 fraction bits, truncated magnitude
// Three stages: magnitudes, four 32x32 partials, sum and sign.
// ----------------------------------------------------------------------------
module hpc_mul (
  input  logic               clk,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  logic [63:0]  ua, ub;
  logic         neg1, neg2;
  logic [63:0]  p00, p01, p10, p11;
  logic [127:0] full;
  logic [62:0]  mm;

  always_ff @(posedge clk) begin
    ua   <= a[63] ? 64'(-a) : 64'(a);
    ub   <= b[63] ? 64'(-b) : 64'(b);
    neg1 <= a[63] ^ b[63];
    p00  <= 64'(ua[31:0])  * 64'(ub[31:0]);
    p01  <= 64'(ua[31:0])  * 64'(ub[63:32]);
    p10  <= 64'(ua[63:32]) * 64'(ub[31:0]);
    p11  <= 64'(ua[63:32]) * 64'(ub[63:32]);
    neg2 <= neg1;
    p    <= neg2 ? -$signed({1'b0, mm}) : $signed({1'b0, mm});
  end

  always_comb begin
    full = {p11, 64'd0} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32) + {64'd0, p00};
    mm   = full[124:62];
  end

endmodule

### src/hpc_front.sv
// ----------------------------------------------------------------------------
// hpc_front: argument classification and reduction
// Six stages: decode, x*16/pi, round to 53 bits, k, k*pi/16, r and index.
// ----------------------------------------------------------------------------
module hpc_front
  import hpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [15:0]             x_bits,
  input  hpc_mode_t               mode,
  output logic                    out_valid,
  output hpc_item_t               out_item,
  output logic [HPC_FRONT_CW-1:0] level
);

  logic        v1, v2, v3, v4, v5;
  logic        nan1, nan2, nan3, nan4, nan5;
  logic        neg1, neg2, neg3, neg4, neg5;
  logic [10:0] m1, m2, m3, m4;
  logic [4:0]  eb1, eb2, eb3, eb4;
  logic [63:0] prod2;
  logic [64:0] prod3, prod3_next;
  logic [19:0] kmag4, kmag_next;
  logic [63:0] kp5, xs5;
  logic [HPC_IDX_W-1:0] idx5;
  logic [63:0] diff, rv;

  // round x*16/pi to 53 significant bits
  always_comb begin
    logic [3:0]  d;
    logic [63:0] mask, rem, half, q;
    logic        up;
    d = '0;
    for (int j = 0; j < 12; j++) begin
      if (prod2[52+j]) d = 4'(j);
    end
    mask = (64'd1 << d) - 64'd1;
    rem  = prod2 & mask;
    half = (d == 4'd0) ? 64'd0 : (64'd1 << (d - 4'd1));
    q    = prod2 >> d;
    up   = hpc_round_up(mode, neg2, q[0], rem != 64'd0, rem > half, rem == half);
    prod3_next = (65'(q) + 65'(up)) << d;
  end

  // k magnitude, nearest even
  always_comb begin
    logic [6:0]  s;
    logic [65:0] p66, q, mask, rem, half;
    logic        up;
    s    = (eb3 <= 5'd10) ? 7'd65 : (7'd75 - 7'(eb3));
    p66  = 66'(prod3);
    q    = p66 >> s;
    mask = (66'd1 << s) - 66'd1;
    rem  = p66 & mask;
    half = 66'd1 << (s - 7'd1);
    up   = (rem > half) || ((rem == half) && q[0]);
    kmag_next = 20'(q) + 20'(up);
  end

  always_comb begin
    diff = xs5 - kp5;
    rv   = neg5 ? (64'd0 - diff) : diff;
  end

  always_ff @(posedge clk) begin
    v1   <= rst ? 1'b0 : accept;
    nan1 <= (x_bits[14:10] == HPC_EXP_MAX);
    neg1 <= x_bits[15];
    m1   <= {(x_bits[14:10] != 5'd0), x_bits[9:0]};
    eb1  <= (x_bits[14:10] == 5'd0) ? 5'd1 : x_bits[14:10];

    v2    <= rst ? 1'b0 : v1;
    nan2  <= nan1;
    neg2  <= neg1;
    m2    <= m1;
    eb2   <= eb1;
    prod2 <= 64'(m1) * HPC_INV_PI16;

    v3    <= rst ? 1'b0 : v2;
    nan3  <= nan2;
    neg3  <= neg2;
    m3    <= m2;
    eb3   <= eb2;
    prod3 <= prod3_next;

    v4    <= rst ? 1'b0 : v3;
    nan4  <= nan3;
    neg4  <= neg3;
    m4    <= m3;
    eb4   <= eb3;
    kmag4 <= kmag_next;

    v5   <= rst ? 1'b0 : v4;
    nan5 <= nan4;
    neg5 <= neg4;
    kp5  <= 64'(kmag4) * HPC_PI16;
    xs5  <= 64'(m4) << (6'(eb4) + 6'd30);
    idx5 <= neg4 ? HPC_IDX_W'(20'd0 - kmag4) : kmag4[HPC_IDX_W-1:0];

    out_valid    <= rst ? 1'b0 : v5;
    out_item.nan <= nan5;
    out_item.idx <= idx5;
    out_item.r   <= $signed(rv << 7);
  end

  assign level = HPC_FRONT_CW'(v1) + HPC_FRONT_CW'(v2) + HPC_FRONT_CW'(v3)
               + HPC_FRONT_CW'(v4) + HPC_FRONT_CW'(v5) + HPC_FRONT_CW'(out_valid);

endmodule

### src/hpc_queue.sv
// ----------------------------------------------------------------------------
// hpc_queue: short queue between front and back end
// The back end drains one word a cycle whenever the queue holds one.
// ----------------------------------------------------------------------------
module hpc_queue
  import hpc_pkg::*;
#(
  parameter int DEPTH = HPC_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  hpc_item_t                  din,
  output logic                       pop,
  output hpc_item_t                  dout,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  hpc_item_t        mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;

  assign pop  = (level != LW'(0));
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      level <= level + LW'(push) - LW'(pop);
    end
  end

endmodule

### src/hpc_back.sv
// ----------------------------------------------------------------------------
// hpc_back: polynomial, table combine and rounding to binary16
// Four multiply levels of three stages each, then five stages of rounding.
// ----------------------------------------------------------------------------
module hpc_back
  import hpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  hpc_item_t   in_item,
  input  hpc_mode_t   mode,
  output logic        done,
  output logic [15:0] cos_bits,
  output logic        invalid_flag
);

  typedef struct packed {
    logic                 v;
    logic                 nan;
    logic [HPC_IDX_W-1:0] idx;
    logic signed [63:0]   r;
    logic signed [63:0]   r2;
  } ctx_t;

  ctx_t b0, g1 [3], g2 [3], g3 [3];
  logic signed [63:0] r2_w, r4_w, r3_w, t24_w, t6_w, ca_w, sb_w;
  logic               cs_v, cs_nan;
  logic signed [63:0] cp, sp, ct, st;
  logic [1:0]         g4 [3];
  logic               rs_v, rs_nan;
  logic signed [63:0] res;
  logic               h1_v, h1_nan, h1_neg;
  logic [63:0]        h1_mag;
  logic               h2_v, h2_nan, h2_neg;
  logic [63:0]        h2_mag;
  logic [7:0]         h2_nz;
  logic [2:0]         h2_lead [8];
  logic               h3_v, h3_nan, h3_neg, h3_zero, h3_nz, h3_gt, h3_eq;
  logic [10:0]        h3_q;
  logic [5:0]         h3_sh;
  logic [7:0]         nz_next;
  logic [2:0]         lead_next [8];
  logic               zero_next, rnz_next, gt_next, eq_next;
  logic [10:0]        q_next;
  logic [5:0]         sh_next;
  logic [15:0]        bits_next;

  hpc_mul mul_a (.clk(clk), .a(b0.r),     .b(b0.r),  .p(r2_w));
  hpc_mul mul_b (.clk(clk), .a(r2_w),     .b(r2_w),  .p(r4_w));
  hpc_mul mul_c (.clk(clk), .a(g1[2].r),  .b(r2_w),  .p(r3_w));
  hpc_mul mul_d (.clk(clk), .a(HPC_C24),  .b(r4_w),  .p(t24_w));
  hpc_mul mul_e (.clk(clk), .a(HPC_C6),   .b(r3_w),  .p(t6_w));
  hpc_mul mul_f (.clk(clk), .a(ct),       .b(cp),    .p(ca_w));
  hpc_mul mul_g (.clk(clk), .a(st),       .b(sp),    .p(sb_w));

  // leading one per byte
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_next[g]   = |h1_mag[8*g +: 8];
      lead_next[g] = '0;
      for (int k = 0; k < 8; k++) begin
        if (h1_mag[8*g+k]) lead_next[g] = 3'(k);
      end
    end
  end

  // position, shift and discarded bits
  always_comb begin
    logic [5:0]  p;
    logic [63:0] mask, rem, half;
    p = '0;
    for (int g = 0; g < 8; g++) begin
      if (h2_nz[g]) p = {3'(g), h2_lead[g]};
    end
    zero_next = (h2_nz == 8'd0);
    sh_next   = (p > 6'd48) ? (p - 6'd10) : 6'd38;
    mask      = (64'd1 << sh_next) - 64'd1;
    rem       = h2_mag & mask;
    half      = 64'd1 << (sh_next - 6'd1);
    q_next    = 11'(h2_mag >> sh_next);
    rnz_next  = (rem != 64'd0);
    gt_next   = (rem > half);
    eq_next   = (rem == half);
  end

  // round and pack
  always_comb begin
    logic [11:0] q1;
    logic [5:0]  sh1;
    logic [14:0] mag15;
    q1  = 12'(h3_q) + 12'(hpc_round_up(mode, h3_neg, h3_q[0], h3_nz, h3_gt, h3_eq));
    sh1 = h3_sh;
    if (q1 == 12'd2048) begin
      q1  = 12'd1024;
      sh1 = h3_sh + 6'd1;
    end
    mag15 = (q1 < 12'd1024) ? 15'(q1) : {5'(sh1 - 6'd37), q1[9:0]};
    if (h3_nan) bits_next = HPC_QNAN;
    else if (h3_zero) bits_next = 16'h0000;
    else bits_next = {h3_neg, mag15};
  end

  always_ff @(posedge clk) begin
    b0.v   <= rst ? 1'b0 : in_valid;
    b0.nan <= in_item.nan;
    b0.idx <= in_item.idx;
    b0.r   <= in_item.r;
    b0.r2  <= '0;

    g1[0] <= b0;
    g1[1] <= g1[0];
    g1[2] <= g1[1];
    g2[0] <= '{v: g1[2].v, nan: g1[2].nan, idx: g1[2].idx, r: g1[2].r, r2: r2_w};
    g2[1] <= g2[0];
    g2[2] <= g2[1];
    g3[0] <= g2[2];
    g3[1] <= g3[0];
    g3[2] <= g3[1];

    cs_v   <= g3[2].v;
    cs_nan <= g3[2].nan;
    cp     <= HPC_ONE - (g3[2].r2 >>> 1) + t24_w;
    sp     <= g3[2].r - t6_w;
    ct     <= hpc_cos_rom(g3[2].idx) <<< 6;
    st     <= hpc_sin_rom(g3[2].idx) <<< 6;

    g4[0] <= {cs_v, cs_nan};
    g4[1] <= g4[0];
    g4[2] <= g4[1];

    rs_v   <= g4[2][1];
    rs_nan <= g4[2][0];
    res    <= ca_w - sb_w;

    h1_v   <= rs_v;
    h1_nan <= rs_nan;
    h1_neg <= res[63];
    h1_mag <= res[63] ? 64'(-res) : 64'(res);

    h2_v    <= h1_v;
    h2_nan  <= h1_nan;
    h2_neg  <= h1_neg;
    h2_mag  <= h1_mag;
    h2_nz   <= nz_next;
    h2_lead <= lead_next;

    h3_v    <= h2_v;
    h3_nan  <= h2_nan;
    h3_neg  <= h2_neg;
    h3_zero <= zero_next;
    h3_nz   <= rnz_next;
    h3_gt   <= gt_next;
    h3_eq   <= eq_next;
    h3_q    <= q_next;
    h3_sh   <= sh_next;

    done         <= h3_v;
    invalid_flag <= h3_nan;
    cos_bits     <= bits_next;

    if (rst) begin
      g1[0].v <= 1'b0; g1[1].v <= 1'b0; g1[2].v <= 1'b0;
      g2[0].v <= 1'b0; g2[1].v <= 1'b0; g2[2].v <= 1'b0;
      g3[0].v <= 1'b0; g3[1].v <= 1'b0; g3[2].v <= 1'b0;
      cs_v <= 1'b0;
      g4[0] <= '0; g4[1] <= '0; g4[2] <= '0;
      rs_v <= 1'b0;
      h1_v <= 1'b0;
      h2_v <= 1'b0;
      h3_v <= 1'b0;
      done <= 1'b0;
    end
  end

endmodule

### tb/half_precision_cosine_unit_test.sv
// ----------------------------------------------------------------------------
// half_precision_cosine_unit_test: self-checking bench for the binary16 cosine
// Drives x words in random bursts, predicts each result with a fixed-point
// cosine model and checks every done word in order, across all rounding modes.
// ----------------------------------------------------------------------------
module half_precision_cosine_unit_test
  import hpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 26;
  localparam int CYCLE_CAP = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] x_bits = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_data = '0;
  logic        done;
  logic [15:0] cos_bits;
  logic        invalid_flag;

  typedef struct {
    logic [15:0] bits;
    logic        inv;
  } cos_word_t;

  cos_word_t   expected_words[$];
  hpc_mode_t   mode_shadow = RM_NEAREST;
  int          mismatches = 0;
  longint      cycle_count = 0;

  half_precision_cosine_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .x_bits(x_bits),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
    .cos_bits(cos_bits), .invalid_flag(invalid_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---- fixed-point cosine model -------------------------------------------

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // signed product at 62 fraction bits, magnitude truncated
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    m = {1'b0, p[124:62]};
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic bump(input hpc_mode_t md, input logic neg, input logic lsb,
                                input logic [63:0] rem, input logic [63:0] half);
    if (rem == 0) return 1'b0;
    case (md)
      RM_NEAREST: return rem > half || (rem == half && lsb);
      RM_ZERO:    return 1'b0;
      RM_UP:      return !neg;
      default:    return neg;
    endcase
  endfunction

  function automatic logic [15:0] pack_half(input logic signed [63:0] v,
                                            input hpc_mode_t md);
    logic [63:0] m, q, rem;
    int p, sh;
    logic [15:0] b;
    m = mag64(v);
    if (m == 0) return 16'h0000;
    p = 63;
    while (p > 0 && !m[p]) p--;
    sh = p - 10;
    if (sh < 38) sh = 38;
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    if (bump(md, v < 0, q[0], rem, 64'd1 << (sh - 1))) q++;
    if (q == 2048) begin
      q = 1024;
      sh++;
    end
    if (q < 1024) b = q[15:0];
    else b = 16'(((sh - 37) << 10) | (q - 1024));
    return {v < 0, b[14:0]};
  endfunction

  // Table values, transcribed as data
  function automatic logic signed [63:0] tbl_cos(input logic [4:0] i);
    logic signed [63:0] t[32];
    t = '{64'sh100000000000000, 64'shfb14be7fbae580, 64'shec835e79946a30,
          64'shd4db3148750d18, 64'shb504f333f9de68, 64'sh8e39d9cd734648,
          64'sh61f78a9abaa590, 64'sh31f17078d34c1a, 64'sd4, -64'sh31f17078d34c10,
          -64'sh61f78a9abaa588, -64'sh8e39d9cd734630, -64'shb504f333f9de60,
          -64'shd4db3148750d20, -64'shec835e79946a30, -64'shfb14be7fbae580,
          -64'sh100000000000000, -64'shfb14be7fbae580, -64'shec835e79946a38,
          -64'shd4db3148750d28, -64'shb504f333f9de70, -64'sh8e39d9cd734640,
          -64'sh61f78a9abaa5b4, -64'sh31f17078d34c32, -64'sd13,
          64'sh31f17078d34c18, 64'sh61f78a9abaa59c, 64'sh8e39d9cd734628,
          64'shb504f333f9de58, 64'shd4db3148750d18, 64'shec835e79946a20,
          64'shfb14be7fbae578};
    return t[i];
  endfunction

  function automatic logic signed [63:0] tbl_sin(input logic [4:0] i);
    logic signed [63:0] t[32];
    t = '{64'sd0, 64'sh31f17078d34c14, 64'sh61f78a9abaa58c, 64'sh8e39d9cd734640,
          64'shb504f333f9de60, 64'shd4db3148750d18, 64'shec835e79946a30,
          64'shfb14be7fbae580, 64'sh100000000000000, 64'shfb14be7fbae580,
          64'shec835e79946a30, 64'shd4db3148750d28, 64'shb504f333f9de68,
          64'sh8e39d9cd734640, 64'sh61f78a9abaa594, 64'sh31f17078d34c2e, 64'sd9,
          -64'sh31f17078d34c1c, -64'sh61f78a9abaa584, -64'sh8e39d9cd734630,
          -64'shb504f333f9de60, -64'shd4db3148750d18, -64'shec835e79946a20,
          -64'shfb14be7fbae578, -64'sh100000000000000, -64'shfb14be7fbae580,
          -64'shec835e79946a28, -64'shd4db3148750d28, -64'shb504f333f9de70,
          -64'sh8e39d9cd734640, -64'sh61f78a9abaa5b8, -64'sh31f17078d34c36};
    return t[i];
  endfunction

  function automatic cos_word_t predict_cosine(input logic [15:0] x, input hpc_mode_t md);
    cos_word_t w;
    logic [4:0] ex;
    logic neg;
    logic [63:0] m, prod, kmag, xs, rmd, q;
    int e, s, len, d;
    logic signed [63:0] k, r, r2, r4, cp, sp, res;
    logic [4:0] idx;
    ex = x[14:10];
    neg = x[15];
    if (ex == HPC_EXP_MAX) begin
      w.bits = HPC_QNAN;
      w.inv = 1'b1;
      return w;
    end
    if (ex == 0) begin
      m = {54'd0, x[9:0]};
      e = -24;
    end else begin
      m = {53'd0, 1'b1, x[9:0]};
      e = int'(ex) - 25;
    end
    // x*16/pi rounded to 53 significant bits in the current mode
    prod = m * HPC_INV_PI16;
    len = 0;
    while (len < 64 && (prod >> len) != 0) len++;
    if (len > 53) begin
      d = len - 53;
      rmd = prod & ((64'd1 << d) - 1);
      q = prod >> d;
      if (bump(md, neg, q[0], rmd, 64'd1 << (d - 1))) q++;
      prod = q << d;
    end
    s = 50 - e;
    if (s >= 65) kmag = 0;
    else if (s == 64) kmag = (prod > (64'd1 << 63)) ? 1 : 0;
    else begin
      q = prod >> s;
      rmd = prod & ((64'd1 << s) - 1);
      if (rmd > (64'd1 << (s - 1)) || (rmd == (64'd1 << (s - 1)) && q[0])) q++;
      kmag = q;
    end
    k = neg ? -$signed(kmag) : $signed(kmag);
    xs = m << (e + 55);
    if (neg) xs = -xs;
    r = $signed(xs - k * HPC_PI16) * 128;
    idx = k[4:0];  // two's complement wrap for negative k
    r2 = qmul(r, r);
    r4 = qmul(r2, r2);
    cp = HPC_ONE - (r2 >>> 1) + qmul(HPC_C24, r4);
    sp = r - qmul(HPC_C6, qmul(r, r2));
    res = qmul(tbl_cos(idx) * 64, cp) - qmul(tbl_sin(idx) * 64, sp);
    w.bits = pack_half(res, md);
    w.inv = 1'b0;
    return w;
  endfunction

  // ---- driving ------------------------------------------------------------

  int burst_left = 0;

  // Offer one word; start stays high across back-to-back sends so that it is
  // never lowered and raised in the same step. A gap lowers it.
  task automatic send_x(input logic [15:0] x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start  <= 1'b1;
    x_bits <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(predict_cosine(x, mode_shadow));
  endtask

  // Idle the sender, wait for the pipe to drain, then write the mode.
  task automatic set_mode(input hpc_mode_t md);
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= md;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_shadow = md;
  endtask

  // ---- checking -----------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
  endtask

  always @(posedge clk) begin
    cos_word_t w;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", cos_bits, 16'h0);
      end else begin
        w = expected_words.pop_front();
        if (cos_bits !== w.bits) report_mismatch("cos_bits", cos_bits, w.bits);
        if (invalid_flag !== w.inv)
          report_mismatch("invalid_flag", {15'd0, invalid_flag}, {15'd0, w.inv});
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---- tests --------------------------------------------------------------

  // extremes, zeros, subnormals, infinities and NaNs
  task automatic test_special_values();
    logic [15:0] v[$];
    v = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03ff, 16'h0400, 16'h3c00,
          16'hbc00, 16'h4248, 16'h4648, 16'h7bff, 16'hfbff, 16'h7c00, 16'hfc00,
          16'h7e00, 16'h7c01, 16'hffff, 16'h5555, 16'haaaa, 16'h3e48, 16'hc248};
    foreach (v[j]) send_x(v[j]);
  endtask

  // mostly finite arguments, all exponents, a few non-finite
  task automatic test_random_args(input int n);
    logic [15:0] x;
    repeat (n) begin
      x = 16'($urandom);
      if ($urandom_range(0, 9) != 0 && x[14:10] == HPC_EXP_MAX) x[14] = 1'b0;
      send_x(x);
    end
  endtask

  task automatic test_all_modes();
    set_mode(RM_ZERO);
    test_special_values();
    test_random_args(90);
    set_mode(RM_UP);
    test_special_values();
    test_random_args(90);
    set_mode(RM_DOWN);
    test_special_values();
    test_random_args(90);
    set_mode(RM_NEAREST);
    test_random_args(70);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_values();
    test_random_args(120);
    test_all_modes();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
